// ----- sv/length_prefixed_file_frame_parser_macros.svh -----
// Assertion macros used by the frame parser checker
`ifndef LENGTH_PREFIXED_FILE_FRAME_PARSER_MACROS_SVH
`define LENGTH_PREFIXED_FILE_FRAME_PARSER_MACROS_SVH

// Clocked assertion, disabled while reset is held
`define LPFF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset
`define LPFF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- sv/lpff_pkg.sv -----
// Shared types and constants of the length-prefixed frame parser
package lpff_pkg;

  localparam int unsigned MAX_NAME_LENGTH_DEF      = 99;
  localparam int unsigned MAX_SIZE_TEXT_LENGTH_DEF = 99;
  localparam int unsigned HEADER_BYTES             = 8;
  localparam int unsigned SH_W                     = 8 * (HEADER_BYTES - 1);
  localparam int unsigned OUT_DATA_W               = 80;

  localparam logic [1:0] PH_HEADER  = 2'd0;
  localparam logic [1:0] PH_NAME    = 2'd1;
  localparam logic [1:0] PH_SIZE    = 2'd2;
  localparam logic [1:0] PH_PAYLOAD = 2'd3;

  localparam logic [2:0] CL_HEADER  = 3'd0;
  localparam logic [2:0] CL_NAME    = 3'd1;
  localparam logic [2:0] CL_SIZE    = 3'd2;
  localparam logic [2:0] CL_PAYLOAD = 3'd3;
  localparam logic [2:0] CL_ERROR   = 3'd4;
  localparam logic [2:0] CL_RESET   = 3'd5;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       end_of_stream;
  } item_t;

  typedef struct packed {
    logic [2:0]  byte_class;
    logic [7:0]  data_byte;
    logic        frame_last;
    logic [6:0]  name_length_out;
    logic [31:0] payload_size_out;
    logic [31:0] byte_index;
  } result_t;

endpackage

// ----- sv/length_prefixed_file_frame_parser.sv -----
// Length-prefixed frame parser top level: input register, frame logic, result register.
// An accepted byte is held in the input register, classified by the frame logic and stored in the result register.
// Throughput: one byte per cycle while the result side is not stalled, set by the single frame-state update per byte.
// While a result waits, the input register accepts a byte only if it is empty.
// Reset (rst_n low, synchronous) empties both registers and returns the parser to a header.
module length_prefixed_file_frame_parser #(
  parameter int unsigned MAX_NAME_LENGTH      = lpff_pkg::MAX_NAME_LENGTH_DEF,
  parameter int unsigned MAX_SIZE_TEXT_LENGTH = lpff_pkg::MAX_SIZE_TEXT_LENGTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [7:0]                      in_tdata,   // [7:0] rx_byte
  input  logic                            in_tuser,   // [0] end_of_stream
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [7:0] data_byte, [14:8] name_length_out, [46:15] payload_size_out,
  // [78:47] byte_index, [79] zero
  output logic [lpff_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic [2:0]                      out_tuser,  // [2:0] byte_class
  output logic                            out_tlast   // frame_last
);

  logic              advance;
  logic              fire;
  logic              stg_valid;
  lpff_pkg::item_t   stg_item;
  lpff_pkg::result_t step_res;
  lpff_pkg::result_t out_res_r;
  logic              out_valid_r;
  logic              out_valid_nxt;

  assign advance = !out_valid_r || out_tready;
  assign fire    = stg_valid && advance;

  lpff_in_reg u_in_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .advance   (advance),
    .stg_valid (stg_valid),
    .stg_item  (stg_item)
  );

  lpff_core #(
    .MAX_NAME_LENGTH      (MAX_NAME_LENGTH),
    .MAX_SIZE_TEXT_LENGTH (MAX_SIZE_TEXT_LENGTH)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .item   (stg_item),
    .result (step_res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = stg_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_res_r <= step_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.byte_class;
  assign out_tlast  = out_res_r.frame_last;
  assign out_tdata  = {1'b0, out_res_r.byte_index, out_res_r.payload_size_out,
                       out_res_r.name_length_out, out_res_r.data_byte};

endmodule

// ----- sv/lpff_in_reg.sv -----
// Input register stage of the frame parser
module lpff_in_reg (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  logic [7:0]     in_tdata,
  input  logic           in_tuser,
  input  logic           advance,
  output logic           stg_valid,
  output lpff_pkg::item_t stg_item
);

  logic            stg_valid_r;
  logic            stg_valid_nxt;
  lpff_pkg::item_t stg_item_r;

  assign in_tready = !stg_valid_r || advance;

  always_comb begin
    stg_valid_nxt = stg_valid_r;
    if (in_tready) begin
      stg_valid_nxt = in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
    end else begin
      stg_valid_r <= stg_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      stg_item_r.rx_byte       <= in_tdata;
      stg_item_r.end_of_stream <= in_tuser;
    end
  end

  assign stg_valid = stg_valid_r;
  assign stg_item  = stg_item_r;

endmodule

// ----- sv/lpff_core.sv -----
// Frame state and per-byte classification of the frame parser
module lpff_core #(
  parameter int unsigned MAX_NAME_LENGTH      = lpff_pkg::MAX_NAME_LENGTH_DEF,
  parameter int unsigned MAX_SIZE_TEXT_LENGTH = lpff_pkg::MAX_SIZE_TEXT_LENGTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  lpff_pkg::item_t   item,
  output lpff_pkg::result_t result
);

  localparam int unsigned NL_W = $clog2(MAX_NAME_LENGTH + 1);
  localparam int unsigned SL_W = $clog2(MAX_SIZE_TEXT_LENGTH + 1);

  logic [1:0]               ph_r,  ph_nxt;
  logic [lpff_pkg::SH_W-1:0] sh_r, sh_nxt;
  logic [31:0]              cnt_r, cnt_nxt;
  logic [NL_W-1:0]          nl_r,  nl_nxt;
  logic [SL_W-1:0]          sl_r,  sl_nxt;
  logic [31:0]              ps_r,  ps_nxt;
  logic                     de_r,  de_nxt;

  logic [32:0] cnt_inc;
  logic [63:0] hdr_word;
  logic [31:0] hdr_nl;
  logic [31:0] hdr_sl;
  logic [35:0] ps_acc;
  logic [31:0] ps_sat;
  logic [31:0] nl_ext;
  logic        is_digit;
  logic        last;
  logic        clr;
  logic [2:0]  cls;

  always_comb begin
    ph_nxt   = ph_r;
    sh_nxt   = sh_r;
    cnt_nxt  = cnt_r;
    nl_nxt   = nl_r;
    sl_nxt   = sl_r;
    ps_nxt   = ps_r;
    de_nxt   = de_r;
    last     = 1'b0;
    clr      = 1'b0;
    cls      = lpff_pkg::CL_HEADER;
    cnt_inc  = {1'b0, cnt_r} + 33'd1;
    hdr_word = {sh_r, item.rx_byte};
    hdr_nl   = hdr_word[63:32];
    hdr_sl   = hdr_word[31:0];
    is_digit = item.rx_byte inside {[8'h30:8'h39]};
    ps_acc   = ({4'd0, ps_r} << 3) + ({4'd0, ps_r} << 1) + {32'd0, item.rx_byte[3:0]};
    ps_sat   = (ps_acc[35:32] != 4'd0) ? 32'hFFFF_FFFF : ps_acc[31:0];

    if (item.end_of_stream) begin
      cls = lpff_pkg::CL_RESET;
      clr = 1'b1;
    end else begin
      case (ph_r)
        lpff_pkg::PH_NAME: begin
          cls = lpff_pkg::CL_NAME;
          if (cnt_inc >= 33'(nl_r)) begin
            cnt_nxt = 32'd0;
            if (sl_r != '0) begin
              ph_nxt = lpff_pkg::PH_SIZE;
            end else if (ps_r != 32'd0) begin
              ph_nxt = lpff_pkg::PH_PAYLOAD;
            end else begin
              last = 1'b1;
            end
          end else begin
            cnt_nxt = cnt_inc[31:0];
          end
        end
        lpff_pkg::PH_SIZE: begin
          cls = lpff_pkg::CL_SIZE;
          if (!de_r) begin
            if (is_digit) begin
              ps_nxt = ps_sat;
            end else begin
              de_nxt = 1'b1;
            end
          end
          if (cnt_inc >= 33'(sl_r)) begin
            cnt_nxt = 32'd0;
            if (ps_nxt != 32'd0) begin
              ph_nxt = lpff_pkg::PH_PAYLOAD;
            end else begin
              last = 1'b1;
            end
          end else begin
            cnt_nxt = cnt_inc[31:0];
          end
        end
        lpff_pkg::PH_PAYLOAD: begin
          cls = lpff_pkg::CL_PAYLOAD;
          if (cnt_inc >= {1'b0, ps_r}) begin
            last = 1'b1;
          end else begin
            cnt_nxt = cnt_inc[31:0];
          end
        end
        default: begin
          cls    = lpff_pkg::CL_HEADER;
          sh_nxt = hdr_word[lpff_pkg::SH_W-1:0];
          if (cnt_inc >= 33'(lpff_pkg::HEADER_BYTES)) begin
            if ((hdr_nl > 32'(MAX_NAME_LENGTH)) || (hdr_sl > 32'(MAX_SIZE_TEXT_LENGTH))) begin
              cls = lpff_pkg::CL_ERROR;
              clr = 1'b1;
            end else begin
              nl_nxt  = hdr_nl[NL_W-1:0];
              sl_nxt  = hdr_sl[SL_W-1:0];
              ps_nxt  = 32'd0;
              de_nxt  = 1'b0;
              cnt_nxt = 32'd0;
              if (hdr_nl != 32'd0) begin
                ph_nxt = lpff_pkg::PH_NAME;
              end else if (hdr_sl != 32'd0) begin
                ph_nxt = lpff_pkg::PH_SIZE;
              end else begin
                last = 1'b1;
              end
            end
          end else begin
            cnt_nxt = cnt_inc[31:0];
          end
        end
      endcase
    end

    nl_ext = 32'(nl_nxt);
    result.byte_class       = cls;
    result.data_byte        = item.rx_byte;
    result.frame_last       = last;
    result.name_length_out  = clr ? 7'd0 : nl_ext[6:0];
    result.payload_size_out = clr ? 32'd0 : ps_nxt;
    result.byte_index       = item.end_of_stream ? 32'd0 : cnt_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r  <= lpff_pkg::PH_HEADER;
      cnt_r <= 32'd0;
      nl_r  <= '0;
      sl_r  <= '0;
      ps_r  <= 32'd0;
      de_r  <= 1'b0;
    end else if (fire) begin
      if (last || clr) begin
        ph_r  <= lpff_pkg::PH_HEADER;
        cnt_r <= 32'd0;
        nl_r  <= '0;
        sl_r  <= '0;
        ps_r  <= 32'd0;
        de_r  <= 1'b0;
      end else begin
        ph_r  <= ph_nxt;
        cnt_r <= cnt_nxt;
        nl_r  <= nl_nxt;
        sl_r  <= sl_nxt;
        ps_r  <= ps_nxt;
        de_r  <= de_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      sh_r <= sh_nxt;
    end
  end

endmodule

// ----- sv/lpff_checker.sv -----
// Port-level assertion checker for the frame parser, bound to the top level
`include "length_prefixed_file_frame_parser_macros.svh"

module lpff_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [lpff_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic [2:0]                      out_tuser,
  input logic                            out_tlast
);

  `LPFF_ASSERT(a_out_hold,
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser)
      && $stable(out_tlast),
    "stalled result changed")
  `LPFF_ASSERT(a_reset_class,
    out_tvalid && (out_tuser == lpff_pkg::CL_RESET) |-> (out_tdata[78:8] == '0) && !out_tlast,
    "reset item carries frame data")
  `LPFF_ASSERT(a_error_class,
    out_tvalid && (out_tuser == lpff_pkg::CL_ERROR) |-> (out_tdata[78:47] == 32'd7)
      && (out_tdata[46:8] == '0) && !out_tlast,
    "length error item malformed")
  `LPFF_ASSERT(a_header_index,
    out_tvalid && (out_tuser == lpff_pkg::CL_HEADER) |-> (out_tdata[78:47] < 32'd8),
    "header offset out of range")
  `LPFF_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_tvalid, "result valid right after reset")

endmodule

bind length_prefixed_file_frame_parser lpff_checker u_lpff_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
